/* sv/trpg_pkg.sv */
// shared types, constants and the circle table builder for the tube ring point generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package trpg_pkg;

    // points per ring minus one
    localparam int SEGMENTS = 16;

    // port payload widths
    localparam int S_TDATA_W = 192;
    localparam int M_TDATA_W = 120;
    localparam int PT_IDX_W  = 6;

    // point counter width
    localparam int IDX_W = $clog2(SEGMENTS + 1);

    // fixed point
    localparam int ONE_Q14 = 16384;
    localparam int MAT_W   = 18;

    // divider: quotient bits retired per cycle, cycles per divide
    localparam int DIV_W             = 32;
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_CYCLES        = DIV_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_CYCLES);

    // queue between matrix builder and point generator
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // circle table builder
    localparam int     CORDIC_STEPS    = 16;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458908, 64'sd85004758,
        64'sd42667333,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
    };
    localparam int TRIG_W = 32;

    // one ring after the matrix is built
    typedef struct packed {
        logic [15:0]             tag;
        logic [2:0][31:0]        ctr;
        logic [30:0]             radius;
        logic [5:0][MAT_W-1:0]   m;
    } ring_job_t;

    // {sin, cos} in Q1.14 for point idx, evaluated at elaboration only
    function automatic logic [TRIG_W-1:0] trig_entry(input int idx);
        longint phase;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint cs;
        longint sn;
        longint c;
        longint s;
        int     quad;
        int     k;
        phase = ((longint'(idx) << 32) / SEGMENTS) & 64'hFFFF_FFFF;
        x = CORDIC_GAIN_Q30;
        y = 0;
        z = phase & 64'h3FFF_FFFF;
        quad = int'(phase >>> 30);
        for (k = 0; k < CORDIC_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[k];
            end
        end
        cs = (x + 32768) >>> 16;
        sn = (y + 32768) >>> 16;
        if (cs > ONE_Q14) cs = ONE_Q14;
        if (cs < -ONE_Q14) cs = -ONE_Q14;
        if (sn > ONE_Q14) sn = ONE_Q14;
        if (sn < -ONE_Q14) sn = -ONE_Q14;
        case (quad)
            0: begin
                c = cs;
                s = sn;
            end
            1: begin
                c = -sn;
                s = cs;
            end
            2: begin
                c = -cs;
                s = -sn;
            end
            default: begin
                c = sn;
                s = -cs;
            end
        endcase
        return {16'(s), 16'(c)};
    endfunction

endpackage

/* sv/trpg_div.sv */
// iterative unsigned divider, four quotient bits per cycle while step is high
// depends on trpg_pkg for widths
`timescale 1ns / 1ps

module trpg_div
    import trpg_pkg::*;
(
    input  logic             aclk,
    input  logic             load,
    input  logic             step,
    input  logic [DIV_W-1:0] numer,
    input  logic [15:0]      denom,
    output logic [DIV_W-1:0] quot
);

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [15:0]      rem_reg, rem_next;
    logic [15:0]      den_reg;

    // restoring steps: numerator shifts out the top, quotient bits shift in
    always_comb begin
        logic [16:0] t;
        quo_next = quo_reg;
        rem_next = rem_reg;
        for (int k = 0; k < DIV_BITS_PER_STEP; k++) begin
            t = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, den_reg}) begin
                t = t - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = t[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end else if (step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quot = quo_reg;

endmodule

/* sv/trpg_front.sv */
// front end: accepts a ring, builds the 2x3 rotation matrix with three dividers
// depends on trpg_pkg and trpg_div
`timescale 1ns / 1ps

module trpg_front
    import trpg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 push,
    output ring_job_t            job,
    input  logic                 q_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [15:0]        tag_reg;
    logic [2:0][31:0]   ctr_reg;
    logic signed [15:0] u_reg, v_reg, w_reg;
    logic [30:0]        rad_reg;
    logic               flip_reg;
    logic               uv_neg_reg;

    logic signed [31:0] uv, uu, vv;
    logic [DIV_W-1:0]   uv_mag;
    logic signed [16:0] w1;
    logic [DIV_W-1:0]   q_uv, q_uu, q_vv;
    logic               accept;

    function automatic logic [MAT_W-1:0] sat18(input logic signed [33:0] x);
        if (x > 34'sd131071) begin
            return 18'h1FFFF;
        end else if (x < -34'sd131072) begin
            return 18'h20000;
        end else begin
            return x[MAT_W-1:0];
        end
    endfunction

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // operand capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            tag_reg    <= s_tdata[15:0];
            ctr_reg[0] <= s_tdata[47:16];
            ctr_reg[1] <= s_tdata[79:48];
            ctr_reg[2] <= s_tdata[111:80];
            u_reg      <= s_tdata[127:112];
            v_reg      <= s_tdata[143:128];
            w_reg      <= s_tdata[159:144];
            rad_reg    <= s_tdata[190:160];
            flip_reg   <= ($signed(s_tdata[159:144]) <= -16'sd16384);
        end
        if (state_reg == ST_MUL) begin
            uv_neg_reg <= uv[31];
        end
    end

    assign uv     = u_reg * v_reg;
    assign uu     = u_reg * u_reg;
    assign vv     = v_reg * v_reg;
    assign uv_mag = uv[31] ? DIV_W'(-uv) : DIV_W'(uv);
    assign w1     = 17'(w_reg) + 17'(ONE_Q14);

    trpg_div u_div_uv (
        .aclk  (aclk),
        .load  (state_reg == ST_MUL),
        .step  (state_reg == ST_DIV),
        .numer (uv_mag),
        .denom (w1[15:0]),
        .quot  (q_uv)
    );

    trpg_div u_div_uu (
        .aclk  (aclk),
        .load  (state_reg == ST_MUL),
        .step  (state_reg == ST_DIV),
        .numer (DIV_W'(uu)),
        .denom (w1[15:0]),
        .quot  (q_uu)
    );

    trpg_div u_div_vv (
        .aclk  (aclk),
        .load  (state_reg == ST_MUL),
        .step  (state_reg == ST_DIV),
        .numer (DIV_W'(vv)),
        .denom (w1[15:0]),
        .quot  (q_vv)
    );

    // matrix from quotients, or the flip matrix when w is at or below -1
    always_comb begin
        job.tag    = tag_reg;
        job.ctr    = ctr_reg;
        job.radius = rad_reg;
        if (flip_reg) begin
            job.m[0] = MAT_W'(-ONE_Q14);
            job.m[1] = '0;
            job.m[2] = '0;
            job.m[3] = '0;
            job.m[4] = MAT_W'(-ONE_Q14);
            job.m[5] = '0;
        end else begin
            job.m[0] = sat18($signed({2'b00, q_vv}) + 34'(w_reg));
            job.m[1] = uv_neg_reg ? sat18($signed({2'b00, q_uv}))
                                  : sat18(-$signed({2'b00, q_uv}));
            job.m[2] = -(MAT_W'(u_reg));
            job.m[3] = job.m[1];
            job.m[4] = sat18($signed({2'b00, q_uu}) + 34'(w_reg));
            job.m[5] = -(MAT_W'(v_reg));
        end
    end

    assign push = (state_reg == ST_PUSH) && !q_full;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_DIV;
                cnt_next   = '0;
            end
            ST_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_CYCLES - 1)) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (!q_full) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* sv/trpg_queue.sv */
// two-entry queue of ring jobs between matrix builder and point generator
// depends on trpg_pkg for ring_job_t
`timescale 1ns / 1ps

module trpg_queue
    import trpg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  ring_job_t job_in,
    output logic      full,
    input  logic      pop,
    output ring_job_t job_out,
    output logic      empty
);

    ring_job_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full    = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign job_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= job_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

/* sv/trpg_back.sv */
// back end: walks the circle table and turns each point through a five-stage pipeline
// depends on trpg_pkg for the job type, table builder and widths
`timescale 1ns / 1ps

module trpg_back
    import trpg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ring_job_t            job,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic [TRIG_W-1:0] trig_rom [SEGMENTS + 1];

    for (genvar g = 0; g <= SEGMENTS; g++) begin : g_rom
        localparam logic [TRIG_W-1:0] ENTRY = trig_entry(g);
        assign trig_rom[g] = ENTRY;
    end

    logic adv, issue, at_last;
    logic [IDX_W-1:0] idx_reg;

    // stage 1: table read
    logic               v1_reg;
    ring_job_t          job1_reg;
    logic signed [15:0] sin1_reg, cos1_reg;
    logic [IDX_W-1:0]   idx1_reg;
    logic               last1_reg;
    // stage 2: radius scaling
    logic               v2_reg;
    logic [15:0]        tag2_reg;
    logic [2:0][31:0]   ctr2_reg;
    logic [5:0][MAT_W-1:0] m2_reg;
    logic signed [33:0] cx2_reg, cy2_reg;
    logic [IDX_W-1:0]   idx2_reg;
    logic               last2_reg;
    // stage 3: matrix products
    logic               v3_reg;
    logic [15:0]        tag3_reg;
    logic [2:0][31:0]   ctr3_reg;
    logic signed [51:0] prod3_reg [6];
    logic [IDX_W-1:0]   idx3_reg;
    logic               last3_reg;
    // stage 4: sums and rounding
    logic               v4_reg;
    logic [15:0]        tag4_reg;
    logic [2:0][31:0]   ctr4_reg;
    logic signed [38:0] rnd4_reg [3];
    logic [IDX_W-1:0]   idx4_reg;
    logic               last4_reg;
    // stage 5: output register
    logic               out_v_reg;
    logic [15:0]        out_tag_reg;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [2:0][31:0]   out_pt_reg;
    logic               out_last_reg;

    logic signed [47:0] rs, rc;
    logic signed [52:0] sum [3];
    logic signed [38:0] rnd [3];
    logic signed [39:0] pt  [3];
    logic [2:0][31:0]   sat;

    // whole pipeline moves together, held while the output waits
    assign adv     = !out_v_reg || m_tready;
    assign issue   = adv && !q_empty;
    assign at_last = (idx_reg == IDX_W'(SEGMENTS));
    assign pop     = issue && at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (issue) begin
            idx_reg <= at_last ? '0 : idx_reg + 1'b1;
        end
    end

    assign rs = $signed({1'b0, job1_reg.radius}) * sin1_reg;
    assign rc = $signed({1'b0, job1_reg.radius}) * cos1_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sum[k] = 53'(prod3_reg[2 * k]) + 53'(prod3_reg[2 * k + 1]) + 53'sd8192;
            rnd[k] = sum[k][52:14];
            pt[k]  = 40'(rnd4_reg[k]) + 40'($signed(ctr4_reg[k]));
            if (pt[k] > 40'sd2147483647) begin
                sat[k] = 32'h7FFF_FFFF;
            end else if (pt[k] < -40'sd2147483648) begin
                sat[k] = 32'h8000_0000;
            end else begin
                sat[k] = pt[k][31:0];
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            job1_reg  <= job;
            sin1_reg  <= trig_rom[idx_reg][31:16];
            cos1_reg  <= trig_rom[idx_reg][15:0];
            idx1_reg  <= idx_reg;
            last1_reg <= at_last;

            tag2_reg  <= job1_reg.tag;
            ctr2_reg  <= job1_reg.ctr;
            m2_reg    <= job1_reg.m;
            cx2_reg   <= rs[47:14];
            cy2_reg   <= rc[47:14];
            idx2_reg  <= idx1_reg;
            last2_reg <= last1_reg;

            tag3_reg     <= tag2_reg;
            ctr3_reg     <= ctr2_reg;
            prod3_reg[0] <= cx2_reg * $signed(m2_reg[0]);
            prod3_reg[1] <= cy2_reg * $signed(m2_reg[3]);
            prod3_reg[2] <= cx2_reg * $signed(m2_reg[1]);
            prod3_reg[3] <= cy2_reg * $signed(m2_reg[4]);
            prod3_reg[4] <= cx2_reg * $signed(m2_reg[2]);
            prod3_reg[5] <= cy2_reg * $signed(m2_reg[5]);
            idx3_reg     <= idx2_reg;
            last3_reg    <= last2_reg;

            tag4_reg  <= tag3_reg;
            ctr4_reg  <= ctr3_reg;
            rnd4_reg  <= rnd;
            idx4_reg  <= idx3_reg;
            last4_reg <= last3_reg;

            out_tag_reg  <= tag4_reg;
            out_idx_reg  <= idx4_reg;
            out_pt_reg   <= sat;
            out_last_reg <= last4_reg;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (adv) begin
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            out_v_reg <= v4_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_pt_reg[2], out_pt_reg[1], out_pt_reg[0],
                       PT_IDX_W'(out_idx_reg), out_tag_reg};

endmodule

/* sv/tube_ring_point_generator_unit.sv */
// top level of the tube ring point generator: matrix front end, job queue, point back end
// depends on trpg_pkg, trpg_front, trpg_queue, trpg_back
`timescale 1ns / 1ps

//  channel  | direction | payload
//  s_axis   | in        | one ring: tag, center xyz, direction uvw, radius
//  m_axis   | out       | one point: tag, index, point xyz; tlast on the closing point
//
//  a ring leaves as SEGMENTS+1 points, one per cycle while m_tready is high, so the point
//  walker in the back end sets the sustained ring rate; the front end takes each ring through
//  capture, multiply, the divider steps (4 quotient bits per cycle) and queue write; the first
//  point passes the table read, radius scaling, product, sum and output registers after issue
//  reset is synchronous on aresetn low and clears state, queue and pipeline valids
//  m_tready low freezes the back pipeline; the front keeps taking rings until the queue fills

module tube_ring_point_generator_unit
    import trpg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // ring_tag[15:0], center_x[47:16], center_y[79:48], center_z[111:80],
    // dir_u[127:112], dir_v[143:128], dir_w[159:144], radius[190:160], zero pad
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    // ring_tag_out[15:0], point_index[21:16], point_x[53:22], point_y[85:54],
    // point_z[117:86], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    // last_point
    output logic                 m_tlast
);

    ring_job_t front_job;
    ring_job_t head_job;
    logic      q_push, q_full;
    logic      q_pop, q_empty;

    // direction to rotation matrix
    trpg_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .push     (q_push),
        .job      (front_job),
        .q_full   (q_full)
    );

    // decouples the matrix build from point output
    trpg_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .job_in  (front_job),
        .full    (q_full),
        .pop     (q_pop),
        .job_out (head_job),
        .empty   (q_empty)
    );

    // circle walk, rotate, translate, saturate
    trpg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .job      (head_job),
        .q_empty  (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* sv/trpg_checker.sv */
// port-level checks for the tube ring point generator, bound to the top level
// depends on trpg_pkg and tube_ring_point_generator_unit
`timescale 1ns / 1ps

module trpg_checker
    import trpg_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic [PT_IDX_W-1:0] exp_idx_reg;
    logic [3:0]          pending_reg;
    logic                in_acc, out_acc, ring_done;

    assign in_acc    = s_tvalid && s_tready;
    assign out_acc   = m_tvalid && m_tready;
    assign ring_done = out_acc && m_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end else begin
            if (out_acc) exp_idx_reg <= m_tlast ? '0 : exp_idx_reg + 1'b1;
            pending_reg <= pending_reg + {3'b000, in_acc} - {3'b000, ring_done};
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result transaction offered right after reset");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[21:16] == exp_idx_reg)
        else $error("point index out of sequence");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tlast == (m_tdata[21:16] == PT_IDX_W'(SEGMENTS)))
        else $error("last flag does not match closing point");

    a_no_orphan_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> pending_reg != '0)
        else $error("point offered with no ring in flight");

endmodule

bind tube_ring_point_generator_unit trpg_checker u_checker (.*);

/* dv/ring_point_checker.sv */
// passive checker for the tube ring point generator: predicts the points of each ring
// and compares them with the point stream; depends on trpg_pkg for widths and SEGMENTS
`timescale 1ns / 1ps

module ring_point_checker
    import trpg_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   points_owed
);

    typedef struct {
        logic [15:0] tag;
        logic [5:0]  idx;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } ring_point_t;

    localparam longint UNIT     = 16384;
    localparam longint MAT_HI   = 131071;
    localparam longint MAT_LO   = -131072;
    localparam longint COORD_HI = 64'sd2147483647;
    localparam longint COORD_LO = -64'sd2147483648;
    localparam longint GAIN_Q30 = 64'sd652032874;
    // arctan(2^-k) in units of 2^-32 turn
    localparam longint ARC_STEP [16] = '{
        64'sd536870912, 64'sd316933406, 64'sd167458908, 64'sd85004758,
        64'sd42667333,  64'sd21354465,  64'sd10679838,  64'sd5340245,
        64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
        64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
    };

    longint      circ_sin [SEGMENTS+1];
    longint      circ_cos [SEGMENTS+1];
    ring_point_t pending_points [$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // unit circle in Q1.14, one entry per point index
    initial begin : circle_table
        longint phase;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint cs;
        longint sn;
        int     i;
        int     k;
        for (i = 0; i <= SEGMENTS; i++) begin
            phase = ((longint'(i) << 32) / SEGMENTS) & 64'hFFFF_FFFF;
            x = GAIN_Q30;
            y = 0;
            z = phase & 64'h3FFF_FFFF;
            for (k = 0; k < 16; k++) begin
                dx = y >>> k;
                dy = x >>> k;
                if (z >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ARC_STEP[k];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ARC_STEP[k];
                end
            end
            cs = clip((x + 32768) >>> 16, -UNIT, UNIT);
            sn = clip((y + 32768) >>> 16, -UNIT, UNIT);
            // turn by the quadrant of the phase
            case (phase >> 30)
                0: begin
                    circ_cos[i] = cs;
                    circ_sin[i] = sn;
                end
                1: begin
                    circ_cos[i] = -sn;
                    circ_sin[i] = cs;
                end
                2: begin
                    circ_cos[i] = -cs;
                    circ_sin[i] = -sn;
                end
                default: begin
                    circ_cos[i] = sn;
                    circ_sin[i] = -cs;
                end
            endcase
        end
    end

    function automatic void build_ring_points(input logic [S_TDATA_W-1:0] d);
        longint      ctr [3];
        longint      mat [6];
        longint      p [3];
        longint      u;
        longint      v;
        longint      w;
        longint      w1;
        longint      rad;
        longint      cx;
        longint      cy;
        longint      r;
        ring_point_t pt;
        int          i;
        int          j;
        ctr[0] = longint'($signed(d[47:16]));
        ctr[1] = longint'($signed(d[79:48]));
        ctr[2] = longint'($signed(d[111:80]));
        u      = longint'($signed(d[127:112]));
        v      = longint'($signed(d[143:128]));
        w      = longint'($signed(d[159:144]));
        rad    = longint'(d[190:160]);
        if (w <= -UNIT) begin
            // direction points down -z: plain flip
            mat = '{-UNIT, 0, 0, 0, -UNIT, 0};
        end else begin
            w1     = UNIT + w;
            mat[0] = clip(v * v / w1 + w, MAT_LO, MAT_HI);
            mat[1] = clip((-(u * v)) / w1, MAT_LO, MAT_HI);
            mat[2] = clip(-u, MAT_LO, MAT_HI);
            mat[3] = mat[1];
            mat[4] = clip(u * u / w1 + w, MAT_LO, MAT_HI);
            mat[5] = clip(-v, MAT_LO, MAT_HI);
        end
        for (i = 0; i <= SEGMENTS; i++) begin
            cx   = (rad * circ_sin[i]) >>> 14;
            cy   = (rad * circ_cos[i]) >>> 14;
            p[0] = cx * mat[0] + cy * mat[3];
            p[1] = cx * mat[1] + cy * mat[4];
            p[2] = cx * mat[2] + cy * mat[5];
            pt.tag  = d[15:0];
            pt.idx  = 6'(i);
            pt.last = (i == SEGMENTS);
            for (j = 0; j < 3; j++) begin
                r = clip(((p[j] + 8192) >>> 14) + ctr[j], COORD_LO, COORD_HI);
                case (j)
                    0: pt.x = r[31:0];
                    1: pt.y = r[31:0];
                    default: pt.z = r[31:0];
                endcase
            end
            pending_points.push_back(pt);
        end
    endfunction

    function automatic void field_check(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            mismatches++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    function automatic void check_point();
        ring_point_t want;
        if (pending_points.size() == 0) begin
            mismatches++;
            $error("point with no ring pending: tag %0d index %0d", m_tdata[15:0],
                   m_tdata[21:16]);
            return;
        end
        want = pending_points.pop_front();
        field_check("ring_tag_out", longint'(want.tag), longint'(m_tdata[15:0]));
        field_check("point_index", longint'(want.idx), longint'(m_tdata[21:16]));
        field_check("point_x", longint'($signed(want.x)), longint'($signed(m_tdata[53:22])));
        field_check("point_y", longint'($signed(want.y)), longint'($signed(m_tdata[85:54])));
        field_check("point_z", longint'($signed(want.z)), longint'($signed(m_tdata[117:86])));
        field_check("last_point", longint'(want.last), longint'(m_tlast));
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) build_ring_points(s_tdata);
            if (m_tvalid && m_tready) check_point();
            points_owed = pending_points.size();
        end
    end

endmodule

/* dv/tube_ring_point_generator_unit_test.sv */
// testbench top for the tube ring point generator: clock, reset, ring stimulus,
// point back-pressure and verdict; depends on trpg_pkg, the block and ring_point_checker
`timescale 1ns / 1ps

module tube_ring_point_generator_unit_test
    import trpg_pkg::*;
();

    // limit well above the slowest legal run, leaving plenty of room
    localparam int CYCLE_LIMIT = 300000;
    // drain after the last point
    localparam int DRAIN_CYCLES = 64;
    // long output stall so the queue fills and the input stalls
    localparam int HOLD_CYCLES = 600;
    localparam int RANDOM_RINGS = 200;

    typedef struct {
        logic [15:0] tag;
        logic [31:0] ctr_x;
        logic [31:0] ctr_y;
        logic [31:0] ctr_z;
        logic [15:0] dir_u;
        logic [15:0] dir_v;
        logic [15:0] dir_w;
        logic [30:0] radius;
    } ring_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // back-pressure controls
    logic rx_hold = 1'b0;   // long stall window, owned by the hold-off process
    logic steady  = 1'b0;   // no idling on either side while set
    int   rx_gap  = 0;
    int   rx_gap_next;

    int rings_sent = 0;
    int cycles     = 0;
    int mismatches;
    int points_owed;

    always #4 aclk = ~aclk;

    always @(posedge aclk) cycles <= cycles + 1;

    tube_ring_point_generator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    ring_point_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .points_owed (points_owed)
    );

    // point receiver: after each transaction draw a random tready-low gap (none while steady),
    // forced low for the whole hold-off window
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
        end else begin
            rx_gap_next = rx_gap;
            if (m_tvalid && m_tready) begin
                rx_gap_next = steady ? 0 : int'($urandom_range(0, 9));
            end else if (rx_gap_next != 0) begin
                rx_gap_next = rx_gap_next - 1;
            end
            rx_gap   <= rx_gap_next;
            m_tready <= !rx_hold && (rx_gap_next == 0);
        end
    end

    // ring layout on s_tdata, lowest bits first, top bit left zero
    function automatic logic [S_TDATA_W-1:0] pack_ring(input ring_t r);
        logic [S_TDATA_W-1:0] d;
        d           = '0;
        d[15:0]     = r.tag;
        d[47:16]    = r.ctr_x;
        d[79:48]    = r.ctr_y;
        d[111:80]   = r.ctr_z;
        d[127:112]  = r.dir_u;
        d[143:128]  = r.dir_v;
        d[159:144]  = r.dir_w;
        d[190:160]  = r.radius;
        return d;
    endfunction

    function automatic ring_t ring_at(input logic [15:0] tag, input logic [31:0] cx,
                                      input logic [31:0] cy, input logic [31:0] cz,
                                      input logic [15:0] u, input logic [15:0] v,
                                      input logic [15:0] w, input logic [30:0] rad);
        ring_t r;
        r.tag    = tag;
        r.ctr_x  = cx;
        r.ctr_y  = cy;
        r.ctr_z  = cz;
        r.dir_u  = u;
        r.dir_v  = v;
        r.dir_w  = w;
        r.radius = rad;
        return r;
    endfunction

    // mostly well-formed rings (unit direction, modest center and radius),
    // the rest raw bits across every field
    function automatic ring_t random_ring();
        ring_t r;
        int    kind;
        int    a;
        int    b;
        int    c;
        int    axis;
        r.tag = 16'($urandom);
        kind  = $urandom_range(0, 9);
        if (kind < 8) begin
            r.ctr_x  = 32'(int'($urandom_range(0, 33554432)) - 16777216);
            r.ctr_y  = 32'(int'($urandom_range(0, 33554432)) - 16777216);
            r.ctr_z  = 32'(int'($urandom_range(0, 33554432)) - 16777216);
            r.radius = 31'($urandom_range(0, 16777216));
            if (kind < 7) begin
                a = int'($urandom_range(0, 23170)) - 11585;
                b = int'($urandom_range(0, 23170)) - 11585;
                c = int'($sqrt(real'(268435456 - a * a - b * b)));
                if ($urandom_range(0, 1) != 0) c = -c;
            end else begin
                // axis-aligned, either sign, including straight down
                a = 0;
                b = 0;
                c = ($urandom_range(0, 1) != 0) ? 16384 : -16384;
            end
            axis = $urandom_range(0, 2);
            case (axis)
                0: begin
                    r.dir_u = 16'(a);
                    r.dir_v = 16'(b);
                    r.dir_w = 16'(c);
                end
                1: begin
                    r.dir_u = 16'(b);
                    r.dir_v = 16'(c);
                    r.dir_w = 16'(a);
                end
                default: begin
                    r.dir_u = 16'(c);
                    r.dir_v = 16'(a);
                    r.dir_w = 16'(b);
                end
            endcase
        end else begin
            r.ctr_x  = $urandom;
            r.ctr_y  = $urandom;
            r.ctr_z  = $urandom;
            r.dir_u  = 16'($urandom);
            r.dir_v  = 16'($urandom);
            r.dir_w  = 16'($urandom);
            r.radius = 31'($urandom);
        end
        return r;
    endfunction

    // offer one ring after a random idle gap and hold it until the transaction
    task automatic send_ring(input ring_t r);
        int gap;
        gap = steady ? 0 : int'($urandom_range(0, 9));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_ring(r);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        rings_sent++;
    endtask

    // output stall once the random part is under way
    initial begin : hold_off
        wait (rings_sent >= 60);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("[tube_ring_point_generator_unit] ERROR");
        $finish;
    end

    initial begin : stimulus
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directions along each axis, both signs; -z takes the flip matrix
        send_ring(ring_at(16'd0, 32'd0, 32'd0, 32'd0, 16'sd0, 16'sd0, 16'sd16384, 31'd65536));
        send_ring(ring_at(16'd1, 32'sd655360, -32'sd327680, 32'sd196608,
                          16'sd16384, 16'sd0, 16'sd0, 31'd131072));
        send_ring(ring_at(16'd2, 32'sd65536, 32'sd65536, -32'sd65536,
                          16'sd0, 16'sd16384, 16'sd0, 31'd98304));
        send_ring(ring_at(16'd3, 32'd0, 32'd0, 32'd0, -16'sd16384, 16'sd0, 16'sd0, 31'd65536));
        send_ring(ring_at(16'd4, 32'd0, 32'd0, 32'd0, 16'sd0, -16'sd16384, 16'sd0, 31'd65536));
        send_ring(ring_at(16'd5, 32'sd100, 32'sd200, 32'sd300,
                          16'sd0, 16'sd0, -16'sd16384, 31'd200000));
        // just above the flip threshold: divisor of one
        send_ring(ring_at(16'd6, 32'd0, 32'd0, 32'd0, 16'sd100, -16'sd100, -16'sd16383,
                          31'd65536));
        // below the field's nominal range, still the flip
        send_ring(ring_at(16'd7, 32'd0, 32'd0, 32'd0, 16'sd0, 16'sd0, -16'sd32768, 31'd65536));
        // far from unit length, both ends of the direction fields
        send_ring(ring_at(16'd8, 32'd0, 32'd0, 32'd0, 16'sd32767, -16'sd32768, 16'sd0,
                          31'd65536));
        send_ring(ring_at(16'd9, 32'd0, 32'd0, 32'd0, -16'sd32768, 16'sd32767, 16'sd32767,
                          31'd65536));
        // diagonal unit directions
        send_ring(ring_at(16'd10, 32'sd1000000, 32'sd2000000, -32'sd3000000,
                          16'sd11585, 16'sd11585, 16'sd0, 31'd300000));
        send_ring(ring_at(16'd11, 32'd0, 32'd0, 32'd0, -16'sd9459, 16'sd9459, 16'sd9459,
                          31'd500000));
        // largest radius against extreme centers: points saturate both ways
        send_ring(ring_at(16'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          16'sd0, 16'sd0, 16'sd16384, 31'h7FFF_FFFF));
        send_ring(ring_at(16'h8000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          16'sd0, 16'sd0, 16'sd16384, 31'h7FFF_FFFF));
        send_ring(ring_at(16'd12, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                          -16'sd16384, 16'sd0, 16'sd0, 31'h7FFF_FFFF));
        send_ring(ring_at(16'd13, 32'd0, 32'd0, 32'd0, 16'sd32767, 16'sd32767, 16'sd0,
                          31'h7FFF_FFFF));
        // zero radius: every point sits on the center
        send_ring(ring_at(16'd14, 32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                          16'sd0, 16'sd0, 16'sd16384, 31'd0));
        // w above one: large positive divisor
        send_ring(ring_at(16'd15, 32'd0, 32'd0, 32'd0, 16'sd4000, -16'sd4000, 16'sd32767,
                          31'd65536));

        for (n = 0; n < RANDOM_RINGS; n++) begin
            // switch to and from stretches without idling now and then
            if (n % 40 == 0) steady <= ($urandom_range(0, 3) == 0);
            send_ring(random_ring());
        end
        s_tvalid <= 1'b0;

        // let the checker see the last ring before polling points_owed
        @(posedge aclk);
        while (points_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("[tube_ring_point_generator_unit] OK");
        end else begin
            $display("[tube_ring_point_generator_unit] ERROR");
        end
        $finish;
    end

endmodule
